// File: design/ffha_pkg.sv
package ffha_pkg;

    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 32;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_FREE  = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;

    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_NOSPACE  = 3'd1;
    localparam logic [2:0] RC_RANGE    = 3'd2;
    localparam logic [2:0] RC_NOTSTART = 3'd3;
    localparam logic [2:0] RC_DOUBLE   = 3'd4;
    localparam logic [2:0] RC_SENTINEL = 3'd5;

    typedef struct packed {
        logic        op;
        logic [15:0] request_bytes;
        logic [15:0] pointer_offset;
        logic        pointer_is_null;
    } req_t;

    typedef struct packed {
        logic [15:0] data_offset;
        logic [2:0]  status_code;
    } rsp_t;

endpackage

// File: design/ffha_if.sv
interface ffha_req_if;
    ffha_pkg::req_t payload;
    logic valid;
    logic ready;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ffha_rsp_if;
    ffha_pkg::rsp_t payload;
    logic valid;
    logic ready;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/first_fit_heap_allocator.sv
// First-fit heap allocator over an arena indexed by 8-byte granule. Each item
// takes one input and returns one result. Header fields live in three memories
// with a shared registered read port; a header read takes an address state and
// then a data state. After reset the block clears the status of every header,
// one granule per cycle (512 granules by default), before it takes its first
// item. An allocate walks blocks in WRD/WCHK, after LAY0-LAY2 for the first
// layout, and splits in SPL1, SPL2, MW2; a free runs FRD, FCHK, PRD, PCHK,
// NCHK and MERGE at most, then DONE presents its result. Allocation rate
// therefore falls with fragmentation.
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input logic clk,
    input logic rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);
    localparam int NGRAN = ARENA_BYTES / 8;
    localparam int GW    = $clog2(NGRAN);
    localparam int SW    = GW + 4;
    localparam int HG    = HEADER_BYTES / 8;
    localparam int EPI   = NGRAN - HG;
    localparam logic [GW:0] NGRAN_W = (GW+1)'(NGRAN);
    localparam logic [SW:0] HB  = (SW+1)'(HEADER_BYTES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LAY0  = 5'd1;
    localparam logic [4:0] S_LAY1  = 5'd2;
    localparam logic [4:0] S_WRD   = 5'd3;
    localparam logic [4:0] S_WCHK  = 5'd4;
    localparam logic [4:0] S_SPL1  = 5'd5;
    localparam logic [4:0] S_SPL2  = 5'd6;
    localparam logic [4:0] S_FRD   = 5'd7;
    localparam logic [4:0] S_FCHK  = 5'd8;
    localparam logic [4:0] S_PRD   = 5'd9;
    localparam logic [4:0] S_PCHK  = 5'd10;
    localparam logic [4:0] S_NRD   = 5'd11;
    localparam logic [4:0] S_NCHK  = 5'd12;
    localparam logic [4:0] S_MERGE = 5'd13;
    localparam logic [4:0] S_MW2   = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;
    localparam logic [4:0] S_LAY2  = 5'd16;
    localparam logic [4:0] S_CLR   = 5'd17;

    logic [1:0]    st_mem [NGRAN];
    logic [SW-1:0] sz_mem [NGRAN];
    logic [GW-1:0] pv_mem [NGRAN];
    logic [1:0]    rd_st_raw;
    logic [SW-1:0] rd_sz;
    logic [GW-1:0] rd_pv;
    logic          laid_out_reg;

    logic [4:0]    state_reg, state_next;
    logic [GW:0]   cur_reg, cur_next;
    logic [GW:0]   steps_reg, steps_next;
    logic [SW:0]   need_reg, need_next;
    logic [SW-1:0] bsz_reg, bsz_next;
    logic [GW-1:0] pv_reg, pv_next;
    logic [1:0]    ps_reg, ps_next;
    logic [SW-1:0] psz_reg, psz_next;
    logic [15:0]   data_reg, data_next;
    logic [2:0]    rc_reg, rc_next;
    logic          out_vld_reg;

    logic          raddr_en;
    logic [GW:0]   raddr;
    logic          we, we_st, we_sz, we_pv;
    logic [GW:0]   waddr;
    logic [1:0]    wst;
    logic [SW-1:0] wsz;
    logic [GW-1:0] wpv;
    logic [GW:0]   rd_addr_reg;

    logic [1:0]    rd_st;
    logic [GW:0]   nx;
    logic [SW+1:0] sum;
    logic signed [17:0] p;

    assign rd_st = rd_addr_reg < NGRAN_W ? rd_st_raw : ffha_pkg::ST_NONE;

    always_ff @(posedge clk)
    begin
        if (raddr_en && raddr < NGRAN_W)
        begin
            rd_st_raw <= st_mem[raddr[GW-1:0]];
            rd_sz     <= sz_mem[raddr[GW-1:0]];
            rd_pv     <= pv_mem[raddr[GW-1:0]];
        end
        if (we && waddr < NGRAN_W)
        begin
            if (we_st) st_mem[waddr[GW-1:0]] <= wst;
            if (we_sz) sz_mem[waddr[GW-1:0]] <= wsz;
            if (we_pv) pv_mem[waddr[GW-1:0]] <= wpv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
        end
        else
        begin
            if (raddr_en)
                rd_addr_reg <= raddr;
        end
    end

    assign req.ready   = state_reg == S_IDLE && !out_vld_reg;
    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = '{data_offset: data_reg, status_code: rc_reg};
    assign nx = cur_reg + (GW+1)'(bsz_reg >> 3);
    assign p  = 18'(signed'(req.payload.pointer_offset));

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        steps_next = steps_reg;
        need_next = need_reg;
        bsz_next = bsz_reg;
        pv_next = pv_reg;
        ps_next = ps_reg;
        psz_next = psz_reg;
        data_next = data_reg;
        rc_next = rc_reg;
        raddr_en = 1'b0;
        raddr = cur_reg;
        we = 1'b0;
        we_st = 1'b0;
        we_sz = 1'b0;
        we_pv = 1'b0;
        waddr = cur_reg;
        wst = ffha_pkg::ST_FREE;
        wsz = '0;
        wpv = '0;
        sum = '0;
        case (state_reg)
            S_CLR:
            begin
                we = 1'b1; we_st = 1'b1;
                wst = ffha_pkg::ST_NONE;
                cur_next = cur_reg + 1'b1;
                if (cur_reg == NGRAN_W - 1'b1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    data_next = '0;
                    rc_next = ffha_pkg::RC_OK;
                    if (!req.payload.op)
                    begin
                        need_next = (SW+1)'(({1'b0, req.payload.request_bytes} + 17'd7)
                                    & ~17'd7);
                        cur_next = (GW+1)'(HG);
                        steps_next = '0;
                        if (!laid_out_reg)
                            state_next = S_LAY0;
                        else
                            state_next = S_WRD;
                        if ({1'b0, req.payload.request_bytes} > 17'(ARENA_BYTES))
                        begin
                            rc_next = ffha_pkg::RC_NOSPACE;
                            state_next = laid_out_reg ? S_DONE : S_LAY0;
                            need_next = '1;
                        end
                    end
                    else if (req.payload.pointer_is_null)
                        state_next = S_DONE;
                    else if (p < 0 || p >= 18'(ARENA_BYTES))
                    begin
                        rc_next = ffha_pkg::RC_RANGE;
                        state_next = S_DONE;
                    end
                    else if (p[2:0] != 3'd0 || p < 18'(HEADER_BYTES))
                    begin
                        rc_next = ffha_pkg::RC_NOTSTART;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next = (GW+1)'((p - 18'(HEADER_BYTES)) >>> 3);
                        state_next = S_FRD;
                    end
                end
            end
            S_LAY0:
            begin
                we = 1'b1; we_st = 1'b1; we_sz = 1'b1; we_pv = 1'b1;
                waddr = '0;
                wst = ffha_pkg::ST_ALLOC;
                wsz = SW'(HEADER_BYTES);
                state_next = S_LAY1;
            end
            S_LAY1:
            begin
                we = 1'b1; we_st = 1'b1; we_sz = 1'b1; we_pv = 1'b1;
                waddr = (GW+1)'(HG);
                wsz = SW'(ARENA_BYTES - 2 * HEADER_BYTES);
                state_next = S_LAY2;
            end
            S_LAY2:
            begin
                we = 1'b1; we_st = 1'b1; we_sz = 1'b1; we_pv = 1'b1;
                waddr = (GW+1)'(EPI);
                wst = ffha_pkg::ST_ALLOC;
                wsz = SW'(HEADER_BYTES);
                wpv = GW'(HG);
                state_next = rc_reg == ffha_pkg::RC_NOSPACE ? S_DONE : S_WRD;
            end
            S_WRD:
            begin
                if (cur_reg >= NGRAN_W || steps_reg > NGRAN_W)
                begin
                    rc_next = ffha_pkg::RC_NOSPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr_en = 1'b1;
                    raddr = cur_reg;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                bsz_next = rd_sz;
                state_next = S_WRD;
                if (rd_st == ffha_pkg::ST_ALLOC)
                begin
                    if (cur_reg == (GW+1)'(EPI))
                    begin
                        rc_next = ffha_pkg::RC_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                        cur_next = cur_reg + (GW+1)'(rd_sz >> 3);
                end
                else if (rd_st != ffha_pkg::ST_FREE)
                begin
                    rc_next = ffha_pkg::RC_NOSPACE;
                    state_next = S_DONE;
                end
                else if ({1'b0, rd_sz} < need_reg + HB)
                    cur_next = cur_reg + (GW+1)'(rd_sz >> 3);
                else
                begin
                    we = 1'b1; we_st = 1'b1;
                    wst = ffha_pkg::ST_ALLOC;
                    data_next = 16'(({5'd0, cur_reg} << 3) + 16'(HEADER_BYTES));
                    if ((SW+1)'(need_reg + HB + HB) < {1'b0, rd_sz})
                        state_next = S_SPL1;
                    else
                        state_next = S_DONE;
                end
            end
            S_SPL1:
            begin
                we = 1'b1; we_st = 1'b1; we_sz = 1'b1; we_pv = 1'b1;
                waddr = cur_reg + (GW+1)'((need_reg + HB) >> 3);
                wsz = SW'({1'b0, bsz_reg} - need_reg - HB);
                wpv = cur_reg[GW-1:0];
                state_next = S_SPL2;
            end
            S_SPL2:
            begin
                we = 1'b1; we_pv = 1'b1;
                waddr = nx;
                wpv = GW'(cur_reg + (GW+1)'((need_reg + HB) >> 3));
                bsz_next = SW'(need_reg + HB);
                state_next = S_MW2;
            end
            S_MW2:
            begin
                we = 1'b1; we_sz = 1'b1;
                waddr = cur_reg;
                wsz = bsz_reg;
                state_next = S_DONE;
            end
            S_FRD:
            begin
                raddr_en = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                bsz_next = rd_sz;
                pv_next = rd_pv;
                state_next = S_DONE;
                if (rd_st != ffha_pkg::ST_FREE && rd_st != ffha_pkg::ST_ALLOC)
                    rc_next = ffha_pkg::RC_NOTSTART;
                else if (rd_st == ffha_pkg::ST_FREE)
                    rc_next = ffha_pkg::RC_DOUBLE;
                else if (cur_reg == '0 || cur_reg == (GW+1)'(EPI))
                    rc_next = ffha_pkg::RC_SENTINEL;
                else
                begin
                    we = 1'b1; we_st = 1'b1;
                    wst = ffha_pkg::ST_FREE;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                raddr_en = 1'b1;
                raddr = {1'b0, pv_reg};
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                ps_next = rd_st;
                psz_next = rd_sz;
                raddr_en = 1'b1;
                raddr = nx;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                state_next = S_DONE;
                we = 1'b1;
                if (ps_reg == ffha_pkg::ST_FREE && rd_st == ffha_pkg::ST_ALLOC)
                begin
                    we_sz = 1'b1;
                    waddr = {1'b0, pv_reg};
                    wsz = psz_reg + bsz_reg;
                    cur_next = nx;
                    state_next = S_MERGE;
                end
                else if (ps_reg == ffha_pkg::ST_ALLOC && rd_st == ffha_pkg::ST_FREE)
                begin
                    we_sz = 1'b1;
                    wsz = bsz_reg + rd_sz;
                    pv_next = cur_reg[GW-1:0];
                    cur_next = nx + (GW+1)'(rd_sz >> 3);
                    state_next = S_MERGE;
                end
                else if (ps_reg == ffha_pkg::ST_FREE && rd_st == ffha_pkg::ST_FREE)
                begin
                    sum = (SW+2)'(psz_reg) + (SW+2)'(bsz_reg) + (SW+2)'(rd_sz);
                    we_sz = 1'b1;
                    waddr = {1'b0, pv_reg};
                    wsz = sum[SW-1:0];
                    cur_next = nx + (GW+1)'(rd_sz >> 3);
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                we = 1'b1; we_pv = 1'b1;
                waddr = cur_reg;
                wpv = pv_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            out_vld_reg  <= 1'b0;
            cur_reg      <= '0;
            steps_reg    <= '0;
            laid_out_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            steps_reg <= steps_next;
            if (state_reg == S_LAY0)
                laid_out_reg <= 1'b1;
            if (state_reg == S_DONE)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg <= need_next;
        bsz_reg  <= bsz_next;
        pv_reg   <= pv_next;
        ps_reg   <= ps_next;
        psz_reg  <= psz_next;
        data_reg <= data_next;
        rc_reg   <= rc_next;
    end
endmodule

// File: design/ffha_checker.sv
module ffha_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] data_offset,
    input logic [2:0]  status_code
);
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status_code <= ffha_pkg::RC_SENTINEL) else $error("bad status");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_code != ffha_pkg::RC_OK |-> data_offset == 16'd0)
        else $error("data on failure");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind first_fit_heap_allocator ffha_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .data_offset(rsp.payload.data_offset), .status_code(rsp.payload.status_code)
);

// File: test/first_fit_heap_allocator_tb.sv
module first_fit_heap_allocator_tb;

    localparam int ARENA = ffha_pkg::ARENA_BYTES_DEF;
    localparam int HDR   = ffha_pkg::HEADER_BYTES_DEF;
    localparam int NGRAN = ARENA / 8;
    localparam int HGRAN = HDR / 8;
    localparam int EPI   = NGRAN - HGRAN;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic clk;
    logic rst_n;

    ffha_req_if req_ch();
    ffha_rsp_if rsp_ch();

    first_fit_heap_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [1:0] hdr_status [NGRAN];
    int         hdr_size [NGRAN];
    int         hdr_prev [NGRAN];

    ffha_pkg::req_t pending_items[$];
    ffha_pkg::rsp_t expected_rsp[$];
    int   live_ptrs[$];
    int   freed_ptrs[$];
    int   send_gap;
    int   recv_gap;
    bit   recv_hold;
    bit   stim_done;
    int   errors;

    function automatic logic [1:0] get_status(input int g);
        return (g >= 0 && g < NGRAN) ? hdr_status[g] : ffha_pkg::ST_NONE;
    endfunction

    function automatic int get_size(input int g);
        return (g >= 0 && g < NGRAN) ? hdr_size[g] : 0;
    endfunction

    function automatic void put_status(input int g, input logic [1:0] st);
        if (g >= 0 && g < NGRAN)
            hdr_status[g] = st;
    endfunction

    function automatic void put_size(input int g, input int sz);
        if (g >= 0 && g < NGRAN)
            hdr_size[g] = sz;
    endfunction

    function automatic void put_prev(input int g, input int pv);
        if (g >= 0 && g < NGRAN)
            hdr_prev[g] = pv;
    endfunction

    function automatic void put_header(input int g, input logic [1:0] st, input int sz,
                                       input int pv);
        put_status(g, st);
        put_size(g, sz);
        put_prev(g, pv);
    endfunction

    function automatic ffha_pkg::rsp_t heap_alloc(input int request);
        ffha_pkg::rsp_t r;
        int need;
        int cur;
        int sz;
        int nb;
        logic [1:0] st;
        r.data_offset = '0;
        r.status_code = ffha_pkg::RC_NOSPACE;
        if (hdr_status[0] == ffha_pkg::ST_NONE)
        begin
            put_header(0, ffha_pkg::ST_ALLOC, HDR, 0);
            put_header(HGRAN, ffha_pkg::ST_FREE, ARENA - 2 * HDR, 0);
            put_header(EPI, ffha_pkg::ST_ALLOC, HDR, HGRAN);
        end
        need = (request + 7) & ~7;
        cur = HGRAN;
        for (int steps = 0; steps <= NGRAN; steps++)
        begin
            st = get_status(cur);
            sz = get_size(cur);
            if (cur >= NGRAN)
                return r;
            if (st == ffha_pkg::ST_ALLOC)
            begin
                if (cur == EPI)
                    return r;
                cur += sz / 8;
                continue;
            end
            if (st != ffha_pkg::ST_FREE)
                return r;
            if (sz < need + HDR)
            begin
                cur += sz / 8;
                continue;
            end
            if (need + 2 * HDR < sz)
            begin
                nb = cur + (need + HDR) / 8;
                put_header(nb, ffha_pkg::ST_FREE, sz - need - HDR, cur);
                put_prev(cur + sz / 8, nb);
                put_size(cur, need + HDR);
            end
            put_status(cur, ffha_pkg::ST_ALLOC);
            r.data_offset = 16'((cur * 8 + HDR) & 16'hFFFF);
            r.status_code = ffha_pkg::RC_OK;
            return r;
        end
        return r;
    endfunction

    function automatic logic [2:0] heap_free(input logic [15:0] raw, input logic is_null);
        int p;
        int b;
        int pv;
        int nx;
        int nn;
        logic [1:0] st;
        logic [1:0] ps;
        logic [1:0] ns;
        if (is_null)
            return ffha_pkg::RC_OK;
        p = int'($signed(raw));
        if (p < 0 || p >= ARENA)
            return ffha_pkg::RC_RANGE;
        if ((p & 7) != 0 || p < HDR)
            return ffha_pkg::RC_NOTSTART;
        b = (p - HDR) / 8;
        st = get_status(b);
        if (st != ffha_pkg::ST_FREE && st != ffha_pkg::ST_ALLOC)
            return ffha_pkg::RC_NOTSTART;
        if (st == ffha_pkg::ST_FREE)
            return ffha_pkg::RC_DOUBLE;
        if (b == 0 || b == EPI)
            return ffha_pkg::RC_SENTINEL;
        put_status(b, ffha_pkg::ST_FREE);
        pv = hdr_prev[b];
        nx = b + get_size(b) / 8;
        ps = get_status(pv);
        ns = get_status(nx);
        if (ps == ffha_pkg::ST_FREE && ns == ffha_pkg::ST_ALLOC)
        begin
            put_size(pv, get_size(pv) + get_size(b));
            put_prev(nx, pv);
        end
        else if (ps == ffha_pkg::ST_ALLOC && ns == ffha_pkg::ST_FREE)
        begin
            nn = nx + get_size(nx) / 8;
            put_size(b, get_size(b) + get_size(nx));
            put_prev(nn, b);
        end
        else if (ps == ffha_pkg::ST_FREE && ns == ffha_pkg::ST_FREE)
        begin
            nn = nx + get_size(nx) / 8;
            put_size(pv, get_size(pv) + get_size(b) + get_size(nx));
            put_prev(nn, pv);
        end
        return ffha_pkg::RC_OK;
    endfunction

    function automatic void predict_item(input ffha_pkg::req_t it);
        ffha_pkg::rsp_t r;
        if (it.op == OP_ALLOC)
        begin
            r = heap_alloc(int'(it.request_bytes));
            if (r.status_code == ffha_pkg::RC_OK)
                live_ptrs.push_back(int'(r.data_offset));
        end
        else
        begin
            r.data_offset = '0;
            r.status_code = heap_free(it.pointer_offset, it.pointer_is_null);
        end
        expected_rsp.push_back(r);
    endfunction

    task automatic add_item(input logic op, input int request, input int ptr,
                            input logic is_null);
        ffha_pkg::req_t it;
        it.op = op;
        it.request_bytes = 16'(request);
        it.pointer_offset = 16'(ptr);
        it.pointer_is_null = is_null;
        pending_items.push_back(it);
    endtask

    task automatic add_random_item();
        int p;
        int idx;
        p = $urandom_range(0, 99);
        if (p < 50 && !(live_ptrs.size() > 30 && p < 35))
        begin
            if ($urandom_range(0, 19) == 0)
                add_item(OP_ALLOC, $urandom_range(0, 65535), $urandom, 1'($urandom));
            else
                add_item(OP_ALLOC, $urandom_range(0, 300), $urandom, 1'($urandom));
        end
        else if (p < 88 && live_ptrs.size() > 0)
        begin
            idx = $urandom_range(0, live_ptrs.size() - 1);
            freed_ptrs.push_back(live_ptrs[idx]);
            add_item(OP_FREE, $urandom, live_ptrs[idx], 1'b0);
            live_ptrs.delete(idx);
        end
        else if (p < 93 && freed_ptrs.size() > 0)
        begin
            idx = $urandom_range(0, freed_ptrs.size() - 1);
            add_item(OP_FREE, $urandom, freed_ptrs[idx] + 8 * $urandom_range(0, 1), 1'b0);
        end
        else if (p < 96)
        begin
            add_item(OP_FREE, $urandom, $urandom_range(0, ARENA / 8) * 8, 1'b0);
        end
        else
        begin
            add_item(OP_FREE, $urandom, $urandom, 1'($urandom));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            if (req_ch.valid && req_ch.ready)
                predict_item(req_ch.payload);
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                req_ch.payload <= pending_items.pop_front();
                req_ch.valid <= 1'b1;
                send_gap <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 7);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        ffha_pkg::rsp_t exp_r;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result data_offset=%0d status_code=%0d",
                             $time, rsp_ch.payload.data_offset, rsp_ch.payload.status_code);
                    errors++;
                end
                else
                begin
                    exp_r = expected_rsp.pop_front();
                    if (rsp_ch.payload.data_offset !== exp_r.data_offset)
                    begin
                        $display("%0t: data_offset expected %0d actual %0d", $time,
                                 exp_r.data_offset, rsp_ch.payload.data_offset);
                        errors++;
                    end
                    if (rsp_ch.payload.status_code !== exp_r.status_code)
                    begin
                        $display("%0t: status_code expected %0d actual %0d", $time,
                                 exp_r.status_code, rsp_ch.payload.status_code);
                        errors++;
                    end
                end
            end
            if (recv_hold)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (rsp_ch.valid && rsp_ch.ready)
                    recv_gap <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 7);
            end
        end
    end

    initial
    begin
        recv_hold = 1'b0;
        wait (stim_done || pending_items.size() > 0);
        repeat (3000) @(posedge clk);
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        #50000000;
        $display("FAIL first_fit_heap_allocator");
        $finish;
    end

    initial
    begin
        int hold_cycles;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        stim_done = 1'b0;
        for (int g = 0; g < NGRAN; g++)
        begin
            hdr_status[g] = ffha_pkg::ST_NONE;
            hdr_size[g] = 0;
            hdr_prev[g] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Frees before the arena exists find no header.
        add_item(OP_FREE, 0, 32, 1'b0);
        add_item(OP_FREE, 0, 0, 1'b1);
        add_item(OP_ALLOC, 0, 0, 1'b0);
        add_item(OP_ALLOC, 1, 0, 1'b0);
        add_item(OP_ALLOC, 8, 0, 1'b0);
        add_item(OP_ALLOC, 65535, 16'hFFFF, 1'b0);
        add_item(OP_ALLOC, 4096, 0, 1'b0);
        add_item(OP_FREE, 16'hFFFF, -8, 1'b0);
        add_item(OP_FREE, 0, -32768, 1'b0);
        add_item(OP_FREE, 0, 4096, 1'b0);
        add_item(OP_FREE, 0, 32767, 1'b0);
        add_item(OP_FREE, 0, 0, 1'b0);
        add_item(OP_FREE, 0, 24, 1'b0);
        add_item(OP_FREE, 0, 69, 1'b0);
        add_item(OP_FREE, 0, 32, 1'b0);
        add_item(OP_FREE, 0, 64, 1'b0);
        add_item(OP_FREE, 0, 64, 1'b0);
        add_item(OP_FREE, 0, 96, 1'b0);
        add_item(OP_FREE, 0, 128, 1'b0);
        add_item(OP_ALLOC, 3960, 0, 1'b0);
        add_item(OP_ALLOC, 3992, 0, 1'b0);
        add_item(OP_ALLOC, 40, 0, 1'b0);
        add_item(OP_FREE, 0, 4064, 1'b0);
        wait (pending_items.size() == 0 && !req_ch.valid && expected_rsp.size() == 0);

        for (int n = 0; n < 1250; n++)
        begin
            while (pending_items.size() > 2)
                @(posedge clk);
            if (n == 600)
            begin
                wait (pending_items.size() == 0 && !req_ch.valid && expected_rsp.size() == 0);
            end
            add_random_item();
        end
        stim_done = 1'b1;
        hold_cycles = 0;
        while ((pending_items.size() > 0 || req_ch.valid || expected_rsp.size() > 0)
               && hold_cycles < 200000)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_rsp.size() == 0 && pending_items.size() == 0)
            $display("PASS first_fit_heap_allocator");
        else
            $display("FAIL first_fit_heap_allocator");
        $finish;
    end
endmodule
